[design/bsfr_pkg.sv]
// Package for the byte-stuffed frame receiver: sizes, codes, state types and
// the command and status structs between the controller and the datapath.
// No dependencies; every other design file but bsfr_ram uses it.
package bsfr_pkg;

    localparam int FRAME_DEPTH = 64;
    localparam int IDX_W       = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FILL_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_DEPTH);
    localparam logic [FILL_W-1:0] FILL_MIN  = FILL_W'(2);

    localparam logic [BYTE_W-1:0] RST_START_BYTE  = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE = 8'd125;
    localparam logic [BYTE_W-1:0] RST_END_BYTE    = 8'd127;

    localparam logic [BYTE_W-1:0] ESC_CODE_START  = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_CODE_ESCAPE = 8'h02;
    localparam logic [BYTE_W-1:0] ESC_CODE_END    = 8'h03;

    typedef enum logic [STATUS_W-1:0] {
        ST_PAYLOAD     = 3'd0,
        ST_MISMATCH    = 3'd1,
        ST_SHORT       = 3'd2,
        ST_OVERFLOW    = 3'd3,
        ST_BADESC      = 3'd4,
        ST_UNEXP_START = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_READ = 2'd1,
        MODE_ESC  = 2'd2
    } t_rx_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START  = 2'd0,
        CFG_ESCAPE = 2'd1,
        CFG_END    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEL_RAW    = 2'd0,
        SEL_START  = 2'd1,
        SEL_ESCAPE = 2'd2,
        SEL_END    = 2'd3
    } t_store_sel;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EVAL = 2'd1,
        S_RD   = 2'd2,
        S_LOAD = 2'd3
    } t_ctrl_state;

    typedef struct packed {
        logic       load_byte;
        logic       clr_frame;
        logic       store;
        t_store_sel store_sel;
        logic       post_status;
        t_status    status_code;
        logic       emit_start;
        logic       rd_issue;
        logic       post_payload;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic is_escape;
        logic is_end;
        logic is_code_start;
        logic is_code_escape;
        logic is_code_end;
        logic full;
        logic short_frame;
        logic sum_ok;
        logic emit_last;
        logic slot_free;
    } t_dp_stat;

endpackage

[design/bsfr_in_if.sv]
// Input channel of the frame receiver: one raw received byte per item.
// Depends on bsfr_pkg for the byte width.
interface bsfr_in_if;
    logic                         valid;
    logic                         ready;
    logic [bsfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[design/bsfr_out_if.sv]
// Output channel of the frame receiver: a payload byte or a status code per item.
// Depends on bsfr_pkg for the field widths.
interface bsfr_out_if;
    logic                           valid;
    logic                           ready;
    logic [bsfr_pkg::BYTE_W-1:0]   payload_byte;
    logic                           last_of_run;
    logic [bsfr_pkg::STATUS_W-1:0] status;

    modport source (output valid, output payload_byte, output last_of_run,
                    output status, input ready);
    modport sink   (input valid, input payload_byte, input last_of_run,
                    input status, output ready);
endinterface

[design/byte_stuffed_frame_receiver_core.sv]
// Byte-stuffed frame receiver: takes one received byte per input item, removes
// the escape stuffing, stores the frame and checks its additive checksum at the
// end byte; a good frame leaves as a run of payload items with the last one
// marked, and each error leaves as one status item. Each byte is accepted and
// then evaluated against the mode, fill count and sum; a status item holds the
// evaluation until the output register is free. A good frame of n payload
// bytes is then read out one byte at a time through the frame store's
// registered read port, and the block accepts the next byte while the final
// item still waits in the output register. Depends on bsfr_pkg, the two channel
// interfaces, bsfr_ctrl, bsfr_dp and bsfr_ram.
module byte_stuffed_frame_receiver_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsfr_pkg::BYTE_W-1:0]    i_cfg_wdata,
    bsfr_in_if.sink                        i_in,
    bsfr_out_if.source                     o_out
);
    import bsfr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bsfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bsfr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_byte      (i_in.rx_byte),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_payload_byte (o_out.payload_byte),
        .o_last_of_run  (o_out.last_of_run),
        .o_status       (o_out.status)
    );

endmodule

[design/bsfr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bsfr_dp.sv]
// Datapath of the frame receiver: configuration registers, byte classification,
// frame store, fill count, running sum and the output register.
// Depends on bsfr_pkg and bsfr_ram.
module bsfr_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsfr_pkg::BYTE_W-1:0]    i_cfg_wdata,
    input  logic [bsfr_pkg::BYTE_W-1:0]    i_rx_byte,
    input  bsfr_pkg::t_dp_cmd              i_cmd,
    output bsfr_pkg::t_dp_stat             o_stat,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [bsfr_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic                           o_last_of_run,
    output logic [bsfr_pkg::STATUS_W-1:0]  o_status
);
    import bsfr_pkg::*;

    logic [BYTE_W-1:0] r_start_b, r_esc_b, r_end_b;
    logic [BYTE_W-1:0] r_byte;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_last, n_last;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    t_status           r_out_status;

    logic [BYTE_W-1:0] store_val;
    logic [BYTE_W-1:0] ram_rdata;
    logic              emit_last;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_b <= RST_START_BYTE;
            r_esc_b   <= RST_ESCAPE_BYTE;
            r_end_b   <= RST_END_BYTE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_START:  r_start_b <= i_cfg_wdata;
                CFG_ESCAPE: r_esc_b   <= i_cfg_wdata;
                CFG_END:    r_end_b   <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_rx_byte;
        end
    end

    always_comb begin
        case (i_cmd.store_sel)
            SEL_RAW:    store_val = r_byte;
            SEL_START:  store_val = r_start_b;
            SEL_ESCAPE: store_val = r_esc_b;
            SEL_END:    store_val = r_end_b;
            default:    store_val = r_byte;
        endcase
    end

    always_comb begin
        n_fill = r_fill;
        n_sum  = r_sum;
        n_last = r_last;
        if (i_cmd.clr_frame) begin
            n_fill = '0;
            n_sum  = '0;
        end else if (i_cmd.store) begin
            n_fill = r_fill + FILL_W'(1);
            n_sum  = r_sum + store_val;
            n_last = store_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
        end else begin
            r_fill <= n_fill;
            r_sum  <= n_sum;
        end
        r_last <= n_last;
    end

    bsfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (r_fill[IDX_W-1:0]),
        .i_wdata (store_val),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // Payload run: the read index walks the store up to the byte before the checksum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.emit_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.post_payload) begin
            r_rd_idx <= r_rd_idx + IDX_W'(1);
        end
    end

    assign emit_last = (FILL_W'(r_rd_idx) + FILL_W'(2)) == r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post_status || i_cmd.post_payload) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.post_status) begin
            r_out_byte   <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= i_cmd.status_code;
        end else if (i_cmd.post_payload) begin
            r_out_byte   <= ram_rdata;
            r_out_last   <= emit_last;
            r_out_status <= ST_PAYLOAD;
        end
    end

    always_comb begin
        o_stat.is_start       = (r_byte == r_start_b);
        o_stat.is_escape      = (r_byte == r_esc_b);
        o_stat.is_end         = (r_byte == r_end_b);
        o_stat.is_code_start  = (r_byte == ESC_CODE_START);
        o_stat.is_code_escape = (r_byte == ESC_CODE_ESCAPE);
        o_stat.is_code_end    = (r_byte == ESC_CODE_END);
        o_stat.full           = (r_fill >= FILL_FULL);
        o_stat.short_frame    = (r_fill < FILL_MIN);
        // The last stored byte is the checksum; the rest of the sum must match it.
        o_stat.sum_ok         = ((r_sum - r_last) == r_last);
        o_stat.emit_last      = emit_last;
        o_stat.slot_free      = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_last_of_run  = r_out_last;
    assign o_status       = r_out_status;

    a_store_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (r_fill < FILL_FULL))
        else $error("store issued into a full frame store");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_PAYLOAD)) |-> (r_out_last && (r_out_byte == '0)))
        else $error("status item without last marker or with nonzero byte");

    a_one_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.post_status && i_cmd.post_payload))
        else $error("status and payload posted in the same cycle");

endmodule

[design/bsfr_ctrl.sv]
// Controller of the frame receiver: the sequencing state machine and the
// receive mode (waiting, reading, after escape). Depends on bsfr_pkg.
module bsfr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bsfr_pkg::t_dp_stat i_stat,
    output bsfr_pkg::t_dp_cmd  o_cmd
);
    import bsfr_pkg::*;

    t_ctrl_state r_state, n_state;
    t_rx_mode    r_mode, n_mode;

    // Decision for the byte under evaluation, before the output-slot check.
    t_rx_mode   d_mode;
    logic       d_clr, d_store, d_post, d_emit;
    t_store_sel d_sel;
    t_status    d_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_WAIT;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        d_mode  = r_mode;
        d_clr   = 1'b0;
        d_store = 1'b0;
        d_sel   = SEL_RAW;
        d_post  = 1'b0;
        d_code  = ST_PAYLOAD;
        d_emit  = 1'b0;
        case (r_mode)
            MODE_WAIT: begin
                if (i_stat.is_start) begin
                    d_clr  = 1'b1;
                    d_mode = MODE_READ;
                end
            end
            MODE_READ: begin
                if (i_stat.is_start) begin
                    d_clr  = 1'b1;
                    d_post = 1'b1;
                    d_code = ST_UNEXP_START;
                end else if (i_stat.is_escape) begin
                    d_mode = MODE_ESC;
                end else if (i_stat.is_end) begin
                    d_mode = MODE_WAIT;
                    if (i_stat.short_frame) begin
                        d_post = 1'b1;
                        d_code = ST_SHORT;
                    end else if (!i_stat.sum_ok) begin
                        d_post = 1'b1;
                        d_code = ST_MISMATCH;
                    end else begin
                        d_emit = 1'b1;
                    end
                end else if (!i_stat.full) begin
                    d_store = 1'b1;
                end else begin
                    d_mode = MODE_WAIT;
                    d_post = 1'b1;
                    d_code = ST_OVERFLOW;
                end
            end
            MODE_ESC: begin
                if (i_stat.full) begin
                    d_mode = MODE_WAIT;
                    d_post = 1'b1;
                    d_code = ST_OVERFLOW;
                end else if (i_stat.is_code_start) begin
                    d_store = 1'b1;
                    d_sel   = SEL_START;
                    d_mode  = MODE_READ;
                end else if (i_stat.is_code_escape) begin
                    d_store = 1'b1;
                    d_sel   = SEL_ESCAPE;
                    d_mode  = MODE_READ;
                end else if (i_stat.is_code_end) begin
                    d_store = 1'b1;
                    d_sel   = SEL_END;
                    d_mode  = MODE_READ;
                end else begin
                    d_mode = MODE_WAIT;
                    d_post = 1'b1;
                    d_code = ST_BADESC;
                end
            end
            default: begin
                d_mode = MODE_WAIT;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_byte = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                // A status item waits here, with nothing committed, until the
                // output register can take it.
                if (!d_post || i_stat.slot_free) begin
                    n_mode            = d_mode;
                    o_cmd.clr_frame   = d_clr;
                    o_cmd.store       = d_store;
                    o_cmd.store_sel   = d_sel;
                    o_cmd.post_status = d_post;
                    o_cmd.status_code = d_code;
                    o_cmd.emit_start  = d_emit;
                    n_state           = d_emit ? S_RD : S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.slot_free) begin
                    o_cmd.post_payload = 1'b1;
                    n_state            = i_stat.emit_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_post_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.post_status || o_cmd.post_payload) |-> i_stat.slot_free)
        else $error("result posted while the output register was occupied");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_byte |=> (r_state == S_EVAL))
        else $error("accepted byte was not evaluated in the next cycle");

    a_emit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_start |=> ((r_state == S_RD) && (r_mode == MODE_WAIT)))
        else $error("payload run did not start from the waiting mode");

endmodule
